/* rtl/porc_pkg.sv */
`timescale 1ns / 1ps
package porc_pkg;

    localparam int TableDepthDef  = 64;
    localparam int LaneCountDef   = 8;
    localparam int WindowTicksDef = 1000;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 63;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_LANE_LIMIT   = 3'd0,
        CFG_WINDOW_LIMIT = 3'd1,
        CFG_ACTIVE_LIMIT = 3'd2,
        CFG_QTY_LIMIT    = 3'd3,
        CFG_PRICE_FLOOR  = 3'd4,
        CFG_PRICE_CEIL   = 3'd5,
        CFG_NOTIONAL     = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        V_ACCEPT   = 3'd0,
        V_BAD_LANE = 3'd1,
        V_DUP      = 3'd2,
        V_FULL     = 3'd3,
        V_QTY      = 3'd4,
        V_PRICE    = 3'd5,
        V_NOTIONAL = 3'd6,
        V_RATE     = 3'd7
    } t_verdict;

    // One classified item as it passes from the front part to the back part.
    typedef struct packed {
        logic        release_op;
        logic [3:0]  lane;
        logic [47:0] key;
        logic [47:0] time_now;
        logic [2:0]  pre_verdict;
        logic [63:0] notional;
    } t_job;

endpackage

/* rtl/porc_front.sv */
`timescale 1ns / 1ps
module porc_front
    import porc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_operation,
    input  logic [3:0]          i_lane,
    input  logic [47:0]         i_order_key,
    input  logic signed [31:0]  i_price_ticks,
    input  logic [31:0]         i_order_quantity,
    input  logic [47:0]         i_time_now,
    input  logic [3:0]          i_lane_lim,
    input  logic [31:0]         i_qty_limit,
    input  logic signed [31:0]  i_price_floor,
    input  logic signed [31:0]  i_price_ceil,
    output logic                o_job_valid,
    input  logic                i_job_ready,
    output t_job                o_job
);

    // Stage one registers the beat and the magnitude; stage two multiplies.
    logic        r_s1_valid;
    t_job        r_s1_job;
    logic [31:0] r_s1_mag;
    logic [31:0] r_s1_qty;
    logic        r_s2_valid;
    t_job        r_s2_job;
    logic        s2_free;
    logic        s1_move;
    logic [3:0]  lanes;
    logic [2:0]  pre;
    logic [32:0] neg_price;
    t_job        s2_next;

    assign s2_free = !r_s2_valid || i_job_ready;
    assign s1_move = r_s1_valid && s2_free;
    assign o_ready = !r_s1_valid || s2_free;
    assign o_job_valid = r_s2_valid;
    assign o_job = r_s2_job;

    always_comb begin
        lanes = (i_lane_lim == 4'd0) ? 4'd1 : i_lane_lim;
        pre = V_ACCEPT;
        if (i_lane >= lanes) begin
            pre = V_BAD_LANE;
        end else if (i_order_key == 48'd0) begin
            pre = V_DUP;
        end else if (i_order_quantity > i_qty_limit) begin
            pre = V_QTY;
        end else if (i_price_ticks < i_price_floor || i_price_ticks > i_price_ceil) begin
            pre = V_PRICE;
        end
        neg_price = 33'd0 - {i_price_ticks[31], i_price_ticks};
    end

    always_comb begin
        s2_next = r_s1_job;
        s2_next.notional = 64'(r_s1_mag) * 64'(r_s1_qty);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (i_job_ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_job.release_op  <= i_operation;
            r_s1_job.lane        <= i_lane;
            r_s1_job.key         <= i_order_key;
            r_s1_job.time_now    <= i_time_now;
            r_s1_job.pre_verdict <= pre;
            r_s1_job.notional    <= 64'd0;
            r_s1_mag <= i_price_ticks[31] ? neg_price[31:0] : i_price_ticks;
            r_s1_qty <= i_order_quantity;
        end
        if (s1_move) begin
            r_s2_job <= s2_next;
        end
    end

endmodule

/* rtl/porc_queue.sv */
`timescale 1ns / 1ps
module porc_queue
    import porc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end

endmodule

/* rtl/porc_back.sv */
`timescale 1ns / 1ps
module porc_back
    import porc_pkg::*;
#(
    parameter int TABLE_DEPTH  = TableDepthDef,
    parameter int LANE_COUNT   = LaneCountDef,
    parameter int WINDOW_TICKS = WindowTicksDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    input  logic [15:0] i_win_limit,
    input  logic [6:0]  i_act_limit,
    input  logic [62:0] i_notional_lim,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_verdict,
    output logic        o_release_hit
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
    localparam int BW = 48 - $clog2(WINDOW_TICKS + 1) + 1;
    localparam int SH = 48 + $clog2(WINDOW_TICKS);
    localparam logic [96:0] SCALE_S = 97'd1 << SH;
    localparam logic [96:0] RECIP = (SCALE_S + 97'(WINDOW_TICKS) - 97'd1) / 97'(WINDOW_TICKS);
    localparam logic [64:0] RECIP_M = RECIP[64:0];

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_CMP   = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_MOVE  = 7'b0010000,
        ST_WRITE = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    t_state      r_state;
    t_job        r_job;
    logic [47:0] r_ids [TABLE_DEPTH];
    logic [47:0] r_rd;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_hit_pos;
    logic        r_found;
    logic [BW-1:0] r_wstart [LANE_COUNT];
    logic [15:0] r_wcnt [LANE_COUNT];
    logic [96:0] r_acc;
    logic [1:0]  r_part;
    logic [BW-1:0] r_quot;
    logic [2:0]  r_verdict;
    logic        r_hit;
    logic        r_out_valid;
    logic [2:0]  r_o_verdict;
    logic        r_o_hit;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [47:0] wr_data;
    logic [CW-1:0] cap;
    logic [LW-1:0] lane_i;
    logic [15:0] wlim;
    logic        restart;
    logic [15:0] cur_cnt;
    logic [15:0] chunk;
    logic [64:0] part_prod;
    logic [96:0] part_sh;
    logic [96:0] acc_sum;

    assign o_job_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_verdict = r_o_verdict;
    assign o_release_hit = r_o_hit;
    assign lane_i = r_job.lane[LW-1:0];
    assign wlim = (i_win_limit == 16'd0) ? 16'd1 : i_win_limit;
    assign cap = ({{(32-7){1'b0}}, i_act_limit} > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                 : CW'(i_act_limit);
    assign restart = (r_wcnt[lane_i] == 16'd0) || (r_wstart[lane_i] != r_quot);
    assign cur_cnt = restart ? 16'd0 : r_wcnt[lane_i];

    // The window number is the time stamp times a fixed reciprocal, taken 16 bits a cycle.
    always_comb begin
        case (r_part)
            2'd1: chunk = r_job.time_now[31:16];
            2'd2: chunk = r_job.time_now[47:32];
            default: chunk = r_job.time_now[15:0];
        endcase
        part_prod = {49'd0, chunk} * RECIP_M;
        case (r_part)
            2'd1: part_sh = {16'd0, part_prod, 16'd0};
            2'd2: part_sh = {part_prod, 32'd0};
            default: part_sh = {32'd0, part_prod};
        endcase
        acc_sum = r_acc + part_sh;
    end

    always_comb begin
        rd_en = 1'b0;
        rd_addr = r_idx[AW-1:0];
        wr_en = 1'b0;
        wr_addr = r_hit_pos;
        wr_data = r_rd;
        if (r_state == ST_READ && r_idx < r_count) rd_en = 1'b1;
        if (r_state == ST_MOVE) begin
            rd_en = 1'b1;
            rd_addr = AW'(r_count - CW'(1));
        end
        if (r_state == ST_WRITE) begin
            wr_en = 1'b1;
            if (!r_job.release_op) begin
                wr_addr = r_count[AW-1:0];
                wr_data = r_job.key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd <= r_ids[rd_addr];
        if (wr_en) r_ids[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LANE_COUNT; i++) begin
                r_wstart[i] <= '0;
                r_wcnt[i] <= 16'd0;
            end
        end else begin
            if (r_out_valid && i_ready && r_state != ST_OUT) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_hit <= 1'b0;
                        r_verdict <= i_job.pre_verdict;
                        if (!i_job.release_op && i_job.pre_verdict == V_BAD_LANE) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    if (r_idx < r_count && !r_found) begin
                        r_state <= ST_CMP;
                    end else if (r_job.release_op) begin
                        r_state <= r_found ? ST_MOVE : ST_OUT;
                    end else if (r_found || r_job.pre_verdict == V_DUP) begin
                        r_verdict <= V_DUP;
                        r_state <= ST_OUT;
                    end else if (r_count >= cap) begin
                        r_verdict <= V_FULL;
                        r_state <= ST_OUT;
                    end else if (r_job.pre_verdict != V_ACCEPT) begin
                        r_state <= ST_OUT;
                    end else if (r_job.notional[62:0] > i_notional_lim) begin
                        r_verdict <= V_NOTIONAL;
                        r_state <= ST_OUT;
                    end else begin
                        r_acc <= '0;
                        r_part <= 2'd0;
                        r_state <= ST_DIV;
                    end
                end
                ST_CMP: begin
                    if (r_rd == r_job.key) begin
                        r_found <= 1'b1;
                        r_hit_pos <= r_idx[AW-1:0];
                    end
                    r_idx <= r_idx + CW'(1);
                    r_state <= ST_READ;
                end
                ST_DIV: begin
                    r_acc <= acc_sum;
                    if (r_part == 2'd2) begin
                        r_quot <= acc_sum[SH +: BW];
                        r_state <= ST_MOVE;
                    end else begin
                        r_part <= r_part + 2'd1;
                    end
                end
                ST_MOVE: begin
                    if (r_job.release_op) begin
                        r_state <= ST_WRITE;
                    end else begin
                        r_wstart[lane_i] <= r_quot;
                        if (cur_cnt >= wlim) begin
                            r_wcnt[lane_i] <= cur_cnt;
                            r_verdict <= V_RATE;
                            r_state <= ST_OUT;
                        end else begin
                            r_wcnt[lane_i] <= cur_cnt + 16'd1;
                            r_state <= ST_WRITE;
                        end
                    end
                end
                ST_WRITE: begin
                    if (r_job.release_op) begin
                        r_count <= r_count - CW'(1);
                        r_hit <= 1'b1;
                    end else begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_o_verdict <= r_job.release_op ? V_ACCEPT : r_verdict;
                        r_o_hit <= r_hit;
                        r_out_valid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

/* rtl/pretrade_order_risk_check.sv */
`timescale 1ns / 1ps
// A passing order goes through the front input and multiply stages and the two-entry queue;
// the back part then reads and compares each active id in turn, divides the time stamp, checks
// the lane rate and writes the table. A bad lane goes from idle straight to the result.
// The back part handles one item at a time; the front and queue can take new beats meanwhile.
// Synchronous active-low reset restores the register defaults and clears the count, the
// lane windows and all handshake state; the id table itself is not cleared.
module pretrade_order_risk_check
    import porc_pkg::*;
#(
    parameter int TABLE_DEPTH  = TableDepthDef,
    parameter int LANE_COUNT   = LaneCountDef,
    parameter int WINDOW_TICKS = WindowTicksDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_operation,
    input  logic [3:0]           i_lane,
    input  logic [47:0]          i_order_key,
    input  logic signed [31:0]   i_price_ticks,
    input  logic [31:0]          i_order_quantity,
    input  logic [47:0]          i_time_now,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_verdict,
    output logic                 o_release_hit,
    input  logic                 i_cfg_we,
    input  logic [CfgIdxW-1:0]   i_cfg_idx,
    input  logic [CfgDataW-1:0]  i_cfg_data
);

    logic [3:0]  r_lane_lim;
    logic [15:0] r_win_lim;
    logic [6:0]  r_act_lim;
    logic [31:0] r_qty_lim;
    logic signed [31:0] r_floor;
    logic signed [31:0] r_ceil;
    logic [62:0] r_notional;
    logic [3:0]  lane_lim_eff;

    logic f_valid;
    logic f_ready;
    t_job f_job;
    logic q_valid;
    logic q_ready;
    t_job q_job;

    assign lane_lim_eff = ({1'b0, r_lane_lim} > 5'(LANE_COUNT)) ? 4'(LANE_COUNT) : r_lane_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_lim <= 4'd1;
            r_win_lim  <= 16'd1;
            r_act_lim  <= 7'd64;
            r_qty_lim  <= 32'hFFFF_FFFF;
            r_floor    <= 32'sh8000_0000;
            r_ceil     <= 32'sh7FFF_FFFF;
            r_notional <= {63{1'b1}};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LANE_LIMIT:   r_lane_lim <= i_cfg_data[3:0];
                CFG_WINDOW_LIMIT: r_win_lim  <= i_cfg_data[15:0];
                CFG_ACTIVE_LIMIT: r_act_lim  <= i_cfg_data[6:0];
                CFG_QTY_LIMIT:    r_qty_lim  <= i_cfg_data[31:0];
                CFG_PRICE_FLOOR:  r_floor    <= i_cfg_data[31:0];
                CFG_PRICE_CEIL:   r_ceil     <= i_cfg_data[31:0];
                CFG_NOTIONAL:     r_notional <= i_cfg_data;
                default: ;
            endcase
        end
    end

    porc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_lane(i_lane), .i_order_key(i_order_key),
        .i_price_ticks(i_price_ticks), .i_order_quantity(i_order_quantity),
        .i_time_now(i_time_now),
        .i_lane_lim(lane_lim_eff), .i_qty_limit(r_qty_lim),
        .i_price_floor(r_floor), .i_price_ceil(r_ceil),
        .o_job_valid(f_valid), .i_job_ready(f_ready), .o_job(f_job)
    );

    porc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_job(f_job),
        .o_valid(q_valid), .i_ready(q_ready), .o_job(q_job)
    );

    porc_back #(
        .TABLE_DEPTH(TABLE_DEPTH), .LANE_COUNT(LANE_COUNT), .WINDOW_TICKS(WINDOW_TICKS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(q_valid), .o_job_ready(q_ready), .i_job(q_job),
        .i_win_limit(r_win_lim), .i_act_limit(r_act_lim), .i_notional_lim(r_notional),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_verdict(o_verdict), .o_release_hit(o_release_hit)
    );

`ifndef SYNTH
    a_release_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_release_hit) |-> (o_verdict == V_ACCEPT))
        else $error("release hit with non-zero verdict");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_verdict) && $stable(o_release_hit)))
        else $error("result changed while stalled");
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (u_queue.r_cnt != 2'd3))
        else $error("queue overflow");
`endif

endmodule

/* verif/pretrade_order_risk_check_tb.sv */
`timescale 1ns / 1ps
module pretrade_order_risk_check_tb;
    import porc_pkg::*;

    localparam int Depth = 64;
    localparam int Lanes = 8;
    localparam int Ticks = 1000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_operation = 1'b0;
    logic [3:0] i_lane = '0;
    logic [47:0] i_order_key = '0;
    logic signed [31:0] i_price_ticks = '0;
    logic [31:0] i_order_quantity = '0;
    logic [47:0] i_time_now = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [2:0] o_verdict;
    logic o_release_hit;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    pretrade_order_risk_check dut (.*);

    always #2 i_clk = ~i_clk;

    typedef struct {
        t_verdict verdict;
        logic     hit;
    } t_outcome;

    // Shadow copy of the block's limits and books.
    logic [3:0] lane_lim;
    logic [15:0] win_lim;
    logic [6:0] act_lim;
    logic [31:0] qty_lim;
    logic signed [31:0] px_floor, px_ceil;
    logic [62:0] notion_lim;
    logic [47:0] book_ids[Depth];
    int unsigned book_count;
    logic [47:0] win_start[Lanes];
    int unsigned win_count[Lanes];

    t_outcome verdicts_due[$];
    int unsigned errors = 0;
    logic [47:0] clock_ticks = '0;
    logic [47:0] key_pool[$];

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic int find_key(input logic [47:0] key);
        for (int i = 0; i < book_count; i++)
            if (book_ids[i] == key) return i;
        return -1;
    endfunction

    function automatic t_verdict screen_order(input logic [3:0] lane, input logic [47:0] key,
                                             input logic signed [31:0] px,
                                             input logic [31:0] qty, input logic [47:0] now);
        int unsigned lanes_used;
        int unsigned cap;
        logic [63:0] mag;
        logic [47:0] bucket;
        int unsigned lim;
        lanes_used = (lane_lim == 0) ? 1 : ((lane_lim > Lanes) ? Lanes : lane_lim);
        cap = (act_lim > Depth) ? Depth : act_lim;
        if (lane >= lanes_used) return V_BAD_LANE;
        if (key == 0 || find_key(key) >= 0) return V_DUP;
        if (book_count >= cap) return V_FULL;
        if (qty > qty_lim) return V_QTY;
        if (px < px_floor || px > px_ceil) return V_PRICE;
        mag = px < 0 ? 64'(-(65'(px))) : 64'(px);
        if (mag * 64'(qty) > 64'(notion_lim)) return V_NOTIONAL;
        bucket = now / 48'(Ticks);
        lim = (win_lim == 0) ? 1 : win_lim;
        if (win_count[lane] == 0 || win_start[lane] != bucket) begin
            win_start[lane] = bucket;
            win_count[lane] = 0;
        end
        if (win_count[lane] >= lim) return V_RATE;
        win_count[lane]++;
        book_ids[book_count] = key;
        book_count++;
        return V_ACCEPT;
    endfunction

    task automatic idle_cycles(input int n);
        repeat (n) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [62:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_LANE_LIMIT:   lane_lim = value[3:0];
            CFG_WINDOW_LIMIT: win_lim = value[15:0];
            CFG_ACTIVE_LIMIT: act_lim = value[6:0];
            CFG_QTY_LIMIT:    qty_lim = value[31:0];
            CFG_PRICE_FLOOR:  px_floor = value[31:0];
            CFG_PRICE_CEIL:   px_ceil = value[31:0];
            default:          notion_lim = value;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (verdicts_due.size() != 0) @(negedge i_clk);
        idle_cycles(2 * Depth + 80);
    endtask

    task automatic send_item(input logic op, input logic [3:0] lane, input logic [47:0] key,
                             input logic signed [31:0] px, input logic [31:0] qty,
                             input logic [47:0] now);
        t_outcome res;
        int pos;
        idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17));
        i_valid = 1'b1;
        i_operation <= op;
        i_lane <= lane;
        i_order_key <= key;
        i_price_ticks <= px;
        i_order_quantity <= qty;
        i_time_now <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (op) begin
            pos = find_key(key);
            res.verdict = V_ACCEPT;
            res.hit = 1'b0;
            if (pos >= 0) begin
                book_ids[pos] = book_ids[book_count - 1];
                book_count--;
                res.hit = 1'b1;
            end
        end else begin
            res.verdict = screen_order(lane, key, px, qty, now);
            res.hit = 1'b0;
            if (res.verdict == V_ACCEPT) key_pool = {key_pool, key};
        end
        verdicts_due = {verdicts_due, res};
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Random order or release (one in four), biased towards passing, so the table and rate windows fill up.
    task automatic random_beat();
        logic [47:0] key;
        logic signed [31:0] px;
        logic [31:0] qty;
        logic [3:0] lane;
        clock_ticks += $urandom_range(0, 3) == 0 ? $urandom_range(0, 2500) : $urandom_range(0, 40);
        case ($urandom_range(0, 9))
            0: key = 48'({$urandom, $urandom});
            1: key = 48'd0;
            2, 3: key = key_pool.size() ? key_pool[$urandom_range(0, key_pool.size() - 1)]
                                        : 48'd1;
            default: key = 48'($urandom_range(1, 5000));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            send_item(1'b1, 4'($urandom), key, $urandom, $urandom, 48'({$urandom, $urandom}));
            return;
        end
        lane = $urandom_range(0, 4) == 0 ? 4'($urandom) : 4'($urandom_range(0, 7));
        px = $urandom_range(0, 4) == 0 ? 32'($urandom) : 32'($urandom_range(0, 4000) - 2000);
        qty = $urandom_range(0, 4) == 0 ? 32'($urandom) : 32'($urandom_range(0, 3000));
        send_item(1'b0, lane, key, px, qty,
                  $urandom_range(0, 9) == 0 ? {16'($urandom), $urandom} : clock_ticks);
    endtask

    task automatic test_defaults();
        send_item(1'b0, 4'd0, 48'd7, 32'sh7FFFFFFF, 32'hFFFFFFFF, 48'd5);
        send_item(1'b0, 4'd0, 48'd8, 32'sh80000000, 32'hFFFFFFFF, 48'd6);
        send_item(1'b0, 4'd1, 48'd9, 32'sd1, 32'd1, 48'd7);
        send_item(1'b0, 4'hF, 48'd9, 32'sd1, 32'd1, 48'd7);
        send_item(1'b0, 4'd0, 48'd0, 32'sd1, 32'd1, 48'd7);
        send_item(1'b0, 4'd0, 48'd7, 32'sd1, 32'd1, 48'd7);
        send_item(1'b0, 4'd0, 48'hFFFFFFFFFFFF, 32'sd1, 32'd1, 48'hFFFFFFFFFFFF);
        send_item(1'b1, 4'hF, 48'd7, 32'sd0, 32'd0, 48'd0);
        send_item(1'b1, 4'd0, 48'd7, 32'sd0, 32'd0, 48'd0);
        send_item(1'b1, 4'd0, 48'd0, 32'sd0, 32'd0, 48'd0);
        drain();
    endtask

    task automatic test_limits();
        write_reg(CFG_LANE_LIMIT, 63'd0);
        write_reg(CFG_WINDOW_LIMIT, 63'd0);
        write_reg(CFG_ACTIVE_LIMIT, 63'd127);
        write_reg(CFG_QTY_LIMIT, 63'd100);
        write_reg(CFG_PRICE_FLOOR, 63'(32'hFFFFFF9C));
        write_reg(CFG_PRICE_CEIL, 63'd100);
        write_reg(CFG_NOTIONAL, 63'd5000);
        send_item(1'b0, 4'd1, 48'd20, 32'sd1, 32'd1, 48'd3000);
        send_item(1'b0, 4'd0, 48'd21, 32'sd1, 32'd101, 48'd3000);
        send_item(1'b0, 4'd0, 48'd22, -32'sd101, 32'd1, 48'd3000);
        send_item(1'b0, 4'd0, 48'd23, -32'sd100, 32'd51, 48'd3000);
        send_item(1'b0, 4'd0, 48'd24, -32'sd100, 32'd50, 48'd3000);
        send_item(1'b0, 4'd0, 48'd25, 32'sd1, 32'd1, 48'd3999);
        send_item(1'b0, 4'd0, 48'd26, 32'sd1, 32'd1, 48'd4000);
        drain();
        write_reg(CFG_PRICE_FLOOR, 63'd50);
        write_reg(CFG_PRICE_CEIL, 63'd10);
        write_reg(CFG_ACTIVE_LIMIT, 63'd0);
        send_item(1'b0, 4'd0, 48'd30, 32'sd20, 32'd1, 48'd9000);
        drain();
        write_reg(CFG_ACTIVE_LIMIT, 63'd64);
        send_item(1'b0, 4'd0, 48'd30, 32'sd20, 32'd1, 48'd9000);
        drain();
    endtask

    task automatic test_random(input int beats);
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_LANE_LIMIT, 63'd8);
                    write_reg(CFG_WINDOW_LIMIT, 63'd65535);
                    write_reg(CFG_ACTIVE_LIMIT, 63'd64);
                    write_reg(CFG_QTY_LIMIT, 63'hFFFFFFFF);
                    write_reg(CFG_PRICE_FLOOR, 63'(32'h80000000));
                    write_reg(CFG_PRICE_CEIL, 63'h7FFFFFFF);
                    write_reg(CFG_NOTIONAL, 63'h7FFFFFFFFFFFFFFF);
                end
                1: begin
                    write_reg(CFG_LANE_LIMIT, 63'd15);
                    write_reg(CFG_WINDOW_LIMIT, 63'd3);
                    write_reg(CFG_ACTIVE_LIMIT, 63'd20);
                    write_reg(CFG_NOTIONAL, 63'd2000000);
                end
                2: begin
                    write_reg(CFG_LANE_LIMIT, 63'd4);
                    write_reg(CFG_QTY_LIMIT, 63'd2500);
                    write_reg(CFG_PRICE_FLOOR, 63'(32'hFFFFFC18));
                    write_reg(CFG_PRICE_CEIL, 63'd1500);
                    write_reg(CFG_ACTIVE_LIMIT, 63'd5);
                end
                default: begin
                    write_reg(CFG_WINDOW_LIMIT, 63'd1);
                    write_reg(CFG_ACTIVE_LIMIT, 63'd64);
                    write_reg(CFG_QTY_LIMIT, 63'd0);
                end
            endcase
            for (int n = 0; n < beats / 4; n++) begin
                random_beat();
                if (n == beats / 8) while (verdicts_due.size() != 0) @(negedge i_clk);
            end
            drain();
        end
    endtask

    // Result side: random back-pressure, checks each beat against the oldest verdict.
    initial begin
        t_outcome want;
        int hold;
        forever begin
            @(negedge i_clk);
            hold = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
            i_ready = 1'b0;
            idle_cycles(hold);
            i_ready = 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (verdicts_due.size() == 0) begin
                report("result beat with nothing expected");
            end else begin
                want = verdicts_due.pop_front();
                if (o_verdict !== want.verdict)
                    report($sformatf("verdict %0d, wanted %0d", o_verdict, want.verdict));
                if (o_release_hit !== want.hit)
                    report($sformatf("release_hit %0b, wanted %0b", o_release_hit, want.hit));
            end
        end
    end

    initial begin
        lane_lim = 4'd1;
        win_lim = 16'd1;
        act_lim = 7'd64;
        qty_lim = 32'hFFFFFFFF;
        px_floor = 32'sh80000000;
        px_ceil = 32'sh7FFFFFFF;
        notion_lim = 63'h7FFFFFFFFFFFFFFF;
        book_count = 0;
        for (int i = 0; i < Lanes; i++) begin
            win_start[i] = '0;
            win_count[i] = 0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_defaults();
        test_limits();
        test_random(680);
        if (verdicts_due.size() != 0) report("verdicts still outstanding at the end");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
